/* design/rc6_pkg.sv */
// Shared types, constants and helper functions for the RC6 block cipher.
// No dependencies; used by every module of the block.
`default_nettype none
package rc6_pkg;
  localparam int ROUNDS_DEF        = 20;
  localparam int MAX_KEY_WORDS_DEF = 8;
  localparam int KEY_REG_WORDS     = 8;
  localparam logic [31:0] P32 = 32'hB7E15163;
  localparam logic [31:0] Q32 = 32'h9E3779B9;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_KEY01 = 3'd0,
    REG_KEY23 = 3'd1,
    REG_KEY45 = 3'd2,
    REG_KEY67 = 3'd3,
    REG_COUNT = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_INIT,
    KS_MIX
  } ks_state_t;

  // Block kinds.
  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } blk_t;

  function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    begin
      w = {x, x} << n;
      rol32 = w[63:32];
    end
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    begin
      w = {x, x} >> n;
      ror32 = w[31:0];
    end
  endfunction
endpackage
`default_nettype wire

/* design/rc6_block_cipher.sv */
// RC6-32/20 block cipher engine: configuration port, key schedule, round pipeline.
// Depends on rc6_pkg, rc6_keysched and rc6_round.
//
// Usage: program the key words and word count over the APB-style cfg_ port
// (64-bit registers at byte addresses 0, 8, 16, 24 and 32). Blocks enter on
// the in_ stream: tuser is the kind (0 encrypt, 1 decrypt), tdata the words
// A..D. Results leave on the out_ stream as words A..D.
// The first transfer after reset or after a key or count register write waits for
// key expansion: a start state, a load state, 3*max(c,44) mixing passes and a
// register that marks the keys ready, limited by the single mixing unit. After
// that one block enters every cycle while the receiver does not stall. The
// pipeline has one whitening stage, one stage per round and one final
// whitening stage.
// Reset clears all valid bits and the keys, and the count returns to four.
// When the receiver stalls the whole pipeline holds; nothing is lost.
`default_nettype none
module rc6_block_cipher #(
  parameter int ROUNDS        = rc6_pkg::ROUNDS_DEF,
  parameter int MAX_KEY_WORDS = rc6_pkg::MAX_KEY_WORDS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // word_a_in, word_b_in, word_c_in, word_d_in
  input  wire logic         in_tuser,   // kind
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // word_a_out, word_b_out, word_c_out, word_d_out
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [5:0]   cfg_paddr,
  input  wire logic [63:0]  cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready
);
  import rc6_pkg::*;

  localparam int KT = 2 * ROUNDS + 4;
  localparam int KW = $clog2(KT);

  logic [4*64-1:0] key_regs_r;
  logic [3:0]      count_r;
  logic            ready_r;
  logic            ks_busy, ks_busy_q_r, ks_start;
  logic [KT*32-1:0] rk;
  logic [2:0]      reg_idx;
  logic            wr;
  logic            key_wr;
  logic            en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[5:3];
  assign wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign key_wr = wr & (reg_idx <= REG_COUNT);

  // Register writes; any valid key write invalidates the schedule.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_regs_r <= '0;
      count_r    <= 4'd4;
      ready_r    <= 1'b0;
      ks_busy_q_r <= 1'b0;
    end else begin
      ks_busy_q_r <= ks_busy;
      if (key_wr) ready_r <= 1'b0;
      else if (ks_busy_q_r && !ks_busy) ready_r <= 1'b1;
      if (wr) begin
        case (reg_idx)
          REG_KEY01: key_regs_r[0 +: 64]   <= cfg_pwdata;
          REG_KEY23: key_regs_r[64 +: 64]  <= cfg_pwdata;
          REG_KEY45: key_regs_r[128 +: 64] <= cfg_pwdata;
          REG_KEY67: key_regs_r[192 +: 64] <= cfg_pwdata;
          REG_COUNT: count_r <= cfg_pwdata[3:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY01: cfg_prdata = key_regs_r[0 +: 64];
      REG_KEY23: cfg_prdata = key_regs_r[64 +: 64];
      REG_KEY45: cfg_prdata = key_regs_r[128 +: 64];
      REG_KEY67: cfg_prdata = key_regs_r[192 +: 64];
      REG_COUNT: cfg_prdata = {60'd0, count_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // Expansion is started when a block waits and keys are stale.
  assign ks_start = in_tvalid & ~ready_r & ~ks_busy & ~ks_busy_q_r;

  rc6_keysched #(.ROUNDS(ROUNDS), .MAX_KEY_WORDS(MAX_KEY_WORDS), .KT(KT), .KW(KW)) u_ks (
    .clk(clk), .rst_n(rst_n), .start(ks_start), .key_regs(key_regs_r),
    .key_count(count_r), .busy(ks_busy), .round_keys(rk)
  );

  // Global pipeline enable: the whole pipeline moves unless the output stalls.
  assign en        = ~out_tvalid | out_tready;
  assign in_tready = en & ready_r;

  // Pipeline: stage 0 pre-whitening, ROUNDS round stages, final whitening.
  logic vld   [ROUNDS+2];
  blk_t blk   [ROUNDS+2];
  blk_t pre_nxt, pre_r, post_nxt, post_r;
  logic pre_vld_r, post_vld_r;

  always_comb begin
    pre_nxt.kind = in_tuser;
    pre_nxt.a = in_tdata[31:0];
    pre_nxt.b = in_tdata[63:32];
    pre_nxt.c = in_tdata[95:64];
    pre_nxt.d = in_tdata[127:96];
    if (in_tuser == KIND_ENC) begin
      pre_nxt.b = in_tdata[63:32] + rk[0 +: 32];
      pre_nxt.d = in_tdata[127:96] + rk[32 +: 32];
    end else begin
      pre_nxt.a = in_tdata[31:0] - rk[(2*ROUNDS+2)*32 +: 32];
      pre_nxt.c = in_tdata[95:64] - rk[(2*ROUNDS+3)*32 +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pre_vld_r <= 1'b0;
    else if (en) pre_vld_r <= in_tvalid & in_tready;
  end
  always_ff @(posedge clk) begin
    if (en) pre_r <= pre_nxt;
  end

  assign vld[0] = pre_vld_r;
  assign blk[0] = pre_r;

  for (genvar g = 0; g < ROUNDS; g++) begin : g_rnd
    // Encrypt stage g uses round g+1; decrypt stage g uses round ROUNDS-g.
    rc6_round u_rnd (
      .clk(clk), .en(en), .vld_in(vld[g]), .blk_in(blk[g]),
      .ke_a(rk[(2*(g+1))*32 +: 32]), .ke_c(rk[(2*(g+1)+1)*32 +: 32]),
      .kd_a(rk[(2*(ROUNDS-g))*32 +: 32]), .kd_c(rk[(2*(ROUNDS-g)+1)*32 +: 32]),
      .rst_n(rst_n), .vld_out(vld[g+1]), .blk_out(blk[g+1])
    );
  end

  always_comb begin
    post_nxt = blk[ROUNDS];
    if (blk[ROUNDS].kind == KIND_ENC) begin
      post_nxt.a = blk[ROUNDS].a + rk[(2*ROUNDS+2)*32 +: 32];
      post_nxt.c = blk[ROUNDS].c + rk[(2*ROUNDS+3)*32 +: 32];
    end else begin
      post_nxt.b = blk[ROUNDS].b - rk[0 +: 32];
      post_nxt.d = blk[ROUNDS].d - rk[32 +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) post_vld_r <= 1'b0;
    else if (en) post_vld_r <= vld[ROUNDS];
  end
  always_ff @(posedge clk) begin
    if (en) post_r <= post_nxt;
  end

  assign vld[ROUNDS+1] = post_vld_r;
  assign blk[ROUNDS+1] = post_r;
  assign out_tvalid = vld[ROUNDS+1];
  assign out_tdata  = {blk[ROUNDS+1].d, blk[ROUNDS+1].c, blk[ROUNDS+1].b, blk[ROUNDS+1].a};

  ap_noacc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ks_busy |-> !in_tready) else $error("input taken during key expansion");
  ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result lost under stall");
  ap_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (ks_busy_q_r && !ks_busy) |=> ready_r || $past(wr)) else $error("keys not marked ready");
endmodule
`default_nettype wire

/* design/rc6_keysched.sv */
// Key expansion sequencer and round key store for the RC6 block cipher.
// Depends on rc6_pkg.
`default_nettype none
module rc6_keysched #(
  parameter int ROUNDS        = rc6_pkg::ROUNDS_DEF,
  parameter int MAX_KEY_WORDS = rc6_pkg::MAX_KEY_WORDS_DEF,
  parameter int KT            = 2 * ROUNDS + 4,
  parameter int KW            = $clog2(KT)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [4*64-1:0]             key_regs,
  input  wire logic [3:0]                  key_count,
  output logic                             busy,
  output logic [KT*32-1:0]                 round_keys
);
  import rc6_pkg::*;

  localparam int MW  = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
  localparam int CW  = $clog2(MAX_KEY_WORDS + 1) + 1;
  localparam int PASS_MAX = 3 * ((MAX_KEY_WORDS > KT) ? MAX_KEY_WORDS : KT);
  localparam int NW  = $clog2(PASS_MAX + 1);

  ks_state_t state_r, state_nxt;
  logic [31:0] s_r [KT];
  logic [31:0] l_r [MAX_KEY_WORDS];
  logic [KW-1:0] i_r, i_nxt;
  logic [MW-1:0] j_r, j_nxt;
  logic [NW-1:0] n_r, n_nxt, passes_r;
  logic [CW-1:0] c_r;
  logic [31:0] a_r, b_r;
  logic [31:0] a_new, b_new;
  logic [CW-1:0] c_eff;

  // Clamp the word count into 1..MAX_KEY_WORDS.
  always_comb begin
    if (key_count == 4'd0) c_eff = CW'(1);
    else if (32'(key_count) > MAX_KEY_WORDS) c_eff = CW'(MAX_KEY_WORDS);
    else c_eff = CW'(key_count);
  end

  // One mixing pass per cycle.
  assign a_new = rol32(s_r[i_r] + a_r + b_r, 5'd3);
  assign b_new = rol32(l_r[j_r] + a_new + b_r, a_new[4:0] + b_r[4:0]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      KS_IDLE: if (start) state_nxt = KS_INIT;
      KS_INIT: state_nxt = KS_MIX;
      KS_MIX:  if (n_r == passes_r - NW'(1)) state_nxt = KS_IDLE;
      default: state_nxt = KS_IDLE;
    endcase
  end

  always_comb begin
    i_nxt = (32'(i_r) == KT - 1) ? '0 : i_r + KW'(1);
    j_nxt = (32'(j_r) + 1 == 32'(c_r)) ? '0 : j_r + MW'(1);
    n_nxt = n_r + NW'(1);
  end

  always_comb begin
    busy = (state_r != KS_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath of the sequencer.
  always_ff @(posedge clk) begin
    case (state_r)
      KS_INIT: begin
        for (int k = 0; k < KT; k++) s_r[k] <= P32 + 32'(k) * Q32;
        for (int k = 0; k < MAX_KEY_WORDS; k++)
          l_r[k] <= (k < KEY_REG_WORDS) ? key_regs[k*32 +: 32] : 32'd0;
        c_r      <= c_eff;
        passes_r <= NW'(3 * ((32'(c_eff) > KT) ? 32'(c_eff) : KT));
        a_r <= '0; b_r <= '0; i_r <= '0; j_r <= '0; n_r <= '0;
      end
      KS_MIX: begin
        s_r[i_r] <= a_new;
        l_r[j_r] <= b_new;
        a_r <= a_new; b_r <= b_new;
        i_r <= i_nxt; j_r <= j_nxt; n_r <= n_nxt;
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < KT; g++) begin : g_out
    assign round_keys[g*32 +: 32] = s_r[g];
  end

  ap_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == KS_IDLE && start) |=> busy) else $error("schedule did not start");
  ap_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == KS_INIT) |=> (state_r == KS_MIX)) else $error("init not followed by mix");
endmodule
`default_nettype wire

/* design/rc6_round.sv */
// One pipelined RC6 round stage, encrypt or decrypt by the item's kind.
// Depends on rc6_pkg.
`default_nettype none
module rc6_round (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic         vld_in,
  input  wire rc6_pkg::blk_t blk_in,
  input  wire logic [31:0]  ke_a,
  input  wire logic [31:0]  ke_c,
  input  wire logic [31:0]  kd_a,
  input  wire logic [31:0]  kd_c,
  input  wire logic         rst_n,
  output logic              vld_out,
  output rc6_pkg::blk_t     blk_out
);
  import rc6_pkg::*;

  logic [31:0] t, u, na, nc;
  blk_t blk_nxt, blk_r;
  logic vld_r;

  // Quadratic mixes and rotates of one round.
  always_comb begin
    blk_nxt = blk_in;
    if (blk_in.kind == KIND_ENC) begin
      t  = rol32(blk_in.b * ((blk_in.b << 1) + 32'd1), 5'd5);
      u  = rol32(blk_in.d * ((blk_in.d << 1) + 32'd1), 5'd5);
      na = rol32(blk_in.a ^ t, u[4:0]) + ke_a;
      nc = rol32(blk_in.c ^ u, t[4:0]) + ke_c;
      blk_nxt.a = blk_in.b; blk_nxt.b = nc; blk_nxt.c = blk_in.d; blk_nxt.d = na;
    end else begin
      // Rotate registers right, then undo the round.
      u  = rol32(blk_in.c * ((blk_in.c << 1) + 32'd1), 5'd5);
      t  = rol32(blk_in.a * ((blk_in.a << 1) + 32'd1), 5'd5);
      nc = ror32(blk_in.b - kd_c, t[4:0]) ^ u;
      na = ror32(blk_in.d - kd_a, u[4:0]) ^ t;
      blk_nxt.a = na; blk_nxt.b = blk_in.a; blk_nxt.c = nc; blk_nxt.d = blk_in.c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blk_r <= blk_nxt;
    end
  end

  assign vld_out = vld_r;
  assign blk_out = blk_r;
endmodule
`default_nettype wire

/* tb/rc6_block_cipher_checker.sv */
// Result checker for the RC6 block cipher: watches the register port and both streams,
// predicts each result from its own copy of the key schedule and compares.
// Depends on rc6_pkg for the key expansion constants.
module rc6_block_cipher_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [127:0] in_tdata,   // word_a_in, word_b_in, word_c_in, word_d_in
  input  wire logic         in_tuser,   // kind
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [127:0] out_tdata,  // word_a_out, word_b_out, word_c_out, word_d_out
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [5:0]   cfg_paddr,
  input  wire logic [63:0]  cfg_pwdata,
  input  wire logic         cfg_pready,
  output int                fail_count,
  output int                pending,
  output int                results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import rc6_pkg::*;

  localparam int NUM_ROUNDS = 20;
  localparam int TABLE_LEN  = 2 * NUM_ROUNDS + 4;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } block_words_t;

  logic [63:0]  key_regs [4];
  logic [3:0]   word_count;
  logic         schedule_valid;
  logic [31:0]  round_keys [TABLE_LEN];
  block_words_t expected_blocks [$];

  function automatic logic [31:0] rotate_left(input logic [31:0] x, input logic [4:0] n);
    if (n == 5'd0) return x;
    return (x << n) | (x >> (6'd32 - n));
  endfunction

  function automatic logic [31:0] rotate_right(input logic [31:0] x, input logic [4:0] n);
    if (n == 5'd0) return x;
    return (x >> n) | (x << (6'd32 - n));
  endfunction

  function automatic logic [31:0] quad_mix(input logic [31:0] x);
    logic [31:0] prod;
    prod = x * ((x << 1) + 32'd1);
    return rotate_left(prod, 5'd5);
  endfunction

  // Standard key expansion from the current key registers and word count.
  task automatic expand_schedule();
    logic [31:0] mix_words [8];
    logic [31:0] sa, sb;
    int          cnt, passes, ki, wi;
    cnt = word_count;
    if (cnt == 0) cnt = 1;
    if (cnt > 8) cnt = 8;
    for (int k = 0; k < cnt; k++) mix_words[k] = key_regs[k / 2][(k % 2) * 32 +: 32];
    round_keys[0] = P32;
    for (int k = 1; k < TABLE_LEN; k++) round_keys[k] = round_keys[k - 1] + Q32;
    passes = 3 * ((cnt > TABLE_LEN) ? cnt : TABLE_LEN);
    sa = '0;
    sb = '0;
    ki = 0;
    wi = 0;
    for (int n = 0; n < passes; n++) begin
      sa = rotate_left(round_keys[ki] + sa + sb, 5'd3);
      round_keys[ki] = sa;
      sb = rotate_left(mix_words[wi] + sa + sb, 5'(sa + sb));
      mix_words[wi] = sb;
      ki = (ki + 1 == TABLE_LEN) ? 0 : ki + 1;
      wi = (wi + 1 == cnt) ? 0 : wi + 1;
    end
    schedule_valid = 1'b1;
  endtask

  // Encrypts or decrypts one block with the current round keys.
  function automatic block_words_t cipher_block(input logic kind, input block_words_t blk);
    logic [31:0] a, b, c, d, t, u, s;
    a = blk.a;
    b = blk.b;
    c = blk.c;
    d = blk.d;
    if (kind == KIND_ENC) begin
      b += round_keys[0];
      d += round_keys[1];
      for (int r = 1; r <= NUM_ROUNDS; r++) begin
        t = quad_mix(b);
        u = quad_mix(d);
        a = rotate_left(a ^ t, u[4:0]) + round_keys[2 * r];
        c = rotate_left(c ^ u, t[4:0]) + round_keys[2 * r + 1];
        s = a; a = b; b = c; c = d; d = s;
      end
      a += round_keys[2 * NUM_ROUNDS + 2];
      c += round_keys[2 * NUM_ROUNDS + 3];
    end else begin
      c -= round_keys[2 * NUM_ROUNDS + 3];
      a -= round_keys[2 * NUM_ROUNDS + 2];
      for (int r = NUM_ROUNDS; r >= 1; r--) begin
        s = d; d = c; c = b; b = a; a = s;
        u = quad_mix(d);
        t = quad_mix(b);
        c = rotate_right(c - round_keys[2 * r + 1], t[4:0]) ^ u;
        a = rotate_right(a - round_keys[2 * r], u[4:0]) ^ t;
      end
      d -= round_keys[1];
      b -= round_keys[0];
    end
    return '{a: a, b: b, c: c, d: d};
  endfunction

  // Track register writes, predict on each input transfer, compare on each result transfer.
  always @(posedge clk) begin
    block_words_t blk, want, got;
    reg_idx_t     idx;
    if (!rst_n) begin
      foreach (key_regs[k]) key_regs[k] = '0;
      word_count     = 4'd4;
      schedule_valid = 1'b0;
      expected_blocks.delete();
      fail_count     = 0;
      results_seen   = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        idx = reg_idx_t'(cfg_paddr[5:3]);
        case (idx)
          REG_KEY01, REG_KEY23, REG_KEY45, REG_KEY67: begin
            key_regs[cfg_paddr[4:3]] = cfg_pwdata;
            schedule_valid = 1'b0;
          end
          REG_COUNT: begin
            word_count = cfg_pwdata[3:0];
            schedule_valid = 1'b0;
          end
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (!schedule_valid) expand_schedule();
        blk = '{a: in_tdata[31:0], b: in_tdata[63:32], c: in_tdata[95:64],
                d: in_tdata[127:96]};
        expected_blocks.push_back(cipher_block(in_tuser, blk));
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        got = '{a: out_tdata[31:0], b: out_tdata[63:32], c: out_tdata[95:64],
                d: out_tdata[127:96]};
        if (expected_blocks.size() == 0) begin
          $error("unexpected result transfer: %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_blocks.pop_front();
          if (got.a !== want.a) begin
            $error("word_a_out mismatch: expected %h, got %h", want.a, got.a);
            fail_count++;
          end
          if (got.b !== want.b) begin
            $error("word_b_out mismatch: expected %h, got %h", want.b, got.b);
            fail_count++;
          end
          if (got.c !== want.c) begin
            $error("word_c_out mismatch: expected %h, got %h", want.c, got.c);
            fail_count++;
          end
          if (got.d !== want.d) begin
            $error("word_d_out mismatch: expected %h, got %h", want.d, got.d);
            fail_count++;
          end
        end
      end
    end
    pending = expected_blocks.size();
  end
endmodule

/* tb/rc6_block_cipher_test.sv */
// Top of the RC6 block cipher testbench: clock, reset, stimulus and verdict.
// Depends on rc6_pkg, the rc6_block_cipher design and rc6_block_cipher_checker.
module rc6_block_cipher_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rc6_pkg::*;

  localparam int SETTLE_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int KEY_SETTINGS    = 8;
  localparam int ITEMS_PER_SETUP = 172;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // word_a_in, word_b_in, word_c_in, word_d_in
  logic         in_tuser = 1'b0; // kind
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // word_a_out, word_b_out, word_c_out, word_d_out
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [5:0]   cfg_paddr = '0;
  logic [63:0]  cfg_pwdata = '0;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  int fail_count, pending, results_seen;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int blocks_sent = 0;
  int key_loads = 0;
  int quiet_cycles = 0;

  rc6_block_cipher dut (.*);

  rc6_block_cipher_checker checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending, .results_seen
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Idle modes: none, sender mostly idle, receiver mostly stalling, both lightly.
  task automatic set_idle_mode(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 80; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 80; end
      default: begin send_idle_pct = 21; stall_pct = 21; end
    endcase
  endtask

  // Offers one block and waits for its transfer; valid only drops for an idle gap.
  task automatic send_block(input logic kind, input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c, input logic [31:0] d);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {d, c, b, a};
    do @(posedge clk); while (!in_tready);
    blocks_sent++;
  endtask

  // Waits for every expected result, then lets the pipeline go quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup phase then access phase.
  task automatic write_reg(input int idx, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 6'(idx * 8);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] k01, input logic [63:0] k23,
                          input logic [63:0] k45, input logic [63:0] k67,
                          input logic [3:0] count);
    write_reg(REG_KEY01, k01);
    write_reg(REG_KEY23, k23);
    write_reg(REG_KEY45, k45);
    write_reg(REG_KEY67, k67);
    write_reg(REG_COUNT, 64'(count));
    key_loads++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_key_pair();
    case ($urandom_range(7))
      0: return 64'h0;
      1: return {64{1'b1}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random_blocks(input int n);
    for (int k = 0; k < n; k++)
      send_block(1'($urandom_range(1)), pick_word(), pick_word(), pick_word(), pick_word());
  endtask

  initial begin
    logic [3:0] count;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset key (all zero, four words), extreme and patterned blocks.
    send_block(KIND_ENC, 32'h0, 32'h0, 32'h0, 32'h0);
    send_block(KIND_DEC, 32'h0, 32'h0, 32'h0, 32'h0);
    send_block(KIND_ENC, '1, '1, '1, '1);
    send_block(KIND_DEC, '1, '1, '1, '1);
    send_block(KIND_ENC, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_block(KIND_DEC, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_block(KIND_ENC, 32'h0000_0001, 32'h8000_0000, 32'h0000_001F, 32'h0000_0020);
    settle();

    // Word count of zero behaves as one.
    load_key(pick_key_pair(), pick_key_pair(), pick_key_pair(), pick_key_pair(), 4'd0);
    send_random_blocks(3);
    settle();

    // Count above the maximum with an all-ones key; writes to unmapped indexes ignored.
    load_key({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, 4'd15);
    send_random_blocks(2);
    settle();
    write_reg(5, {64{1'b1}});
    write_reg(7, 64'h0);
    send_random_blocks(2);
    settle();

    // Largest and smallest legal counts.
    load_key(pick_key_pair(), pick_key_pair(), pick_key_pair(), pick_key_pair(), 4'd8);
    send_random_blocks(3);
    settle();
    load_key(pick_key_pair(), pick_key_pair(), pick_key_pair(), pick_key_pair(), 4'd1);
    send_random_blocks(3);
    settle();

    // Random part: several key settings, each run through two idle modes.
    for (int s = 0; s < KEY_SETTINGS; s++) begin
      if (s == 0) count = 4'd8;
      else if (s == 1) count = 4'd1;
      else if (s == KEY_SETTINGS - 1) count = 4'($urandom_range(15, 9));
      else count = 4'($urandom_range(8, 1));
      set_idle_mode(0);
      load_key(pick_key_pair(), pick_key_pair(), pick_key_pair(), pick_key_pair(), count);
      set_idle_mode(s);
      send_random_blocks(ITEMS_PER_SETUP / 2);
      set_idle_mode(s + 1);
      send_random_blocks(ITEMS_PER_SETUP / 2);
      settle();
    end

    set_idle_mode(0);
    settle();
    $display("Sent %0d blocks, checked %0d results over %0d key settings.",
             blocks_sent, results_seen, key_loads);
    $display("Phases covered encrypt and decrypt with sender gaps and receiver stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
